/* rtl/lpr_pkg.sv */
`default_nettype none

package lpr_pkg;

  // defaults for the top level parameters
  localparam int unsigned DefMaxFrames = 16;
  localparam int unsigned DefPageBits  = 16;

  // fixed field widths of the request, result and configuration channels
  localparam int unsigned PageW      = 16;
  localparam int unsigned FrameIdxW  = 4;
  localparam int unsigned FaultCntW  = 32;
  localparam int unsigned CfgW       = 5;

  // frames_in_use after reset
  localparam logic [CfgW-1:0] CfgFramesReset = CfgW'(16);

endpackage

`default_nettype wire

/* rtl/lpr_intf.sv */
`default_nettype none

// page request channel
interface lpr_req_if;
  import lpr_pkg::*;

  logic             valid;
  logic             ready;
  logic [PageW-1:0] page;
  logic             last_request;

  modport source (output valid, output page, output last_request, input ready);
  modport sink   (input valid, input page, input last_request, output ready);
endinterface

// lookup result channel
interface lpr_res_if;
  import lpr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic                 placed;
  logic [FrameIdxW-1:0] frame_index;
  logic                 evicted;
  logic [PageW-1:0]     evicted_page;
  logic [FaultCntW-1:0] fault_count;

  modport source (output valid, output hit, output placed, output frame_index,
                  output evicted, output evicted_page, output fault_count,
                  input ready);
  modport sink   (input valid, input hit, input placed, input frame_index,
                  input evicted, input evicted_page, input fault_count,
                  output ready);
endinterface

// frames_in_use register write channel
interface lpr_cfg_if;
  import lpr_pkg::*;

  logic            valid;
  logic            ready;
  logic [CfgW-1:0] frames_in_use;

  modport source (output valid, output frames_in_use, input ready);
  modport sink   (input valid, input frames_in_use, output ready);
endinterface

`default_nettype wire

/* rtl/lru_page_replacement.sv */
`default_nettype none

// LRU page replacement over a fully associative frame table.
// Pipeline: input register for taken requests, then result register for results.
// Throughput: one request per cycle unless the result channel stalls; table lookup,
// LRU update and fault count update are combinational between these registers.
// Reset: table empty, fault counter zero, frames_in_use set to 16.
module lru_page_replacement #(
  parameter int unsigned MAX_FRAMES = lpr_pkg::DefMaxFrames,
  parameter int unsigned PAGE_BITS  = lpr_pkg::DefPageBits
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  lpr_req_if.sink   req_i,
  lpr_cfg_if.sink   cfg_i,
  lpr_res_if.source res_o
);
  import lpr_pkg::*;

  localparam int unsigned IdxW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned RankW = IdxW;

  // configuration register
  logic [CfgW-1:0] frames_q;

  // frame table
  logic [PAGE_BITS-1:0]  page_q  [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] valid_q;
  logic [RankW-1:0]      rank_q  [MAX_FRAMES];
  logic [FaultCntW-1:0]  faults_q;

  // input register
  logic                 in_vld_q;
  logic [PAGE_BITS-1:0] in_page_q;
  logic                 in_last_q;

  // result register
  logic                 out_vld_q;
  logic                 out_hit_q;
  logic                 out_placed_q;
  logic [FrameIdxW-1:0] out_fidx_q;
  logic                 out_ev_q;
  logic [PageW-1:0]     out_evpage_q;
  logic [FaultCntW-1:0] out_fcnt_q;

  // lookup signals
  logic                  advance;
  logic [31:0]           req_page_w;
  logic [MAX_FRAMES-1:0] active;
  logic [MAX_FRAMES-1:0] match_vec;
  logic [MAX_FRAMES-1:0] free_vec;
  logic [MAX_FRAMES-1:0] victim_vec;
  logic [MAX_FRAMES-1:0] match_oh;
  logic [MAX_FRAMES-1:0] free_oh;
  logic [MAX_FRAMES-1:0] tgt_oh;
  logic                  hit;
  logic                  any_free;
  logic                  any_active;
  logic                  do_fill;
  logic                  do_update;
  logic [IdxW-1:0]       tgt_idx;
  logic [RankW-1:0]      tgt_rank;
  logic [PAGE_BITS-1:0]  evict_pg;
  logic [31:0]           tgt_idx_w;
  logic [31:0]           evict_pg_w;
  logic [FaultCntW-1:0]  faults_d;
  logic [RankW-1:0]      rank_d  [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] valid_d;

  // handshakes
  assign advance     = in_vld_q && (!out_vld_q || res_o.ready);
  assign req_i.ready = !in_vld_q || advance;
  assign cfg_i.ready = 1'b1;

  // page from the port, zero-extended or cut to the stored width
  assign req_page_w = 32'(req_i.page);

  // per-frame compares: active window, hit, free slot
  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      active[i]    = 32'(frames_q) > i;
      match_vec[i] = active[i] && valid_q[i] && (page_q[i] == in_page_q);
      free_vec[i]  = active[i] && !valid_q[i];
    end
  end

  // victim is the active valid frame whose rank is not below any other
  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      victim_vec[i] = active[i] && valid_q[i];
      for (int j = 0; j < MAX_FRAMES; j++) begin
        if (active[j] && valid_q[j] && (rank_q[j] > rank_q[i])) begin
          victim_vec[i] = 1'b0;
        end
      end
    end
  end

  // lowest set bit of the hit and free vectors
  assign match_oh = match_vec & (~match_vec + MAX_FRAMES'(1));
  assign free_oh  = free_vec & (~free_vec + MAX_FRAMES'(1));

  assign hit        = |match_vec;
  assign any_free   = |free_vec;
  assign any_active = (frames_q != '0);
  assign do_fill    = !hit && any_active && any_free;
  assign do_update  = hit || any_active;

  // target frame: hit frame, else free frame, else victim
  always_comb begin
    if (hit) begin
      tgt_oh = match_oh;
    end else if (any_free) begin
      tgt_oh = free_oh;
    end else begin
      tgt_oh = victim_vec;
    end
  end

  // index and rank of the one-hot target, and the page of the victim frame
  always_comb begin
    tgt_idx  = '0;
    tgt_rank = '0;
    evict_pg = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (tgt_oh[i]) begin
        tgt_idx  = tgt_idx | IdxW'(i);
        tgt_rank = tgt_rank | rank_q[i];
      end
      if (victim_vec[i]) begin
        evict_pg = evict_pg | page_q[i];
      end
    end
  end

  assign tgt_idx_w  = 32'(tgt_idx);
  assign evict_pg_w = 32'(evict_pg);

  // saturating fault count
  always_comb begin
    faults_d = faults_q;
    if (!hit && (faults_q != '1)) begin
      faults_d = faults_q + FaultCntW'(1);
    end
  end

  // recency update: target becomes most recent, younger frames age by one
  always_comb begin
    valid_d = valid_q;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      rank_d[i] = rank_q[i];
      if (do_update) begin
        if (tgt_oh[i]) begin
          rank_d[i] = '0;
        end else if (valid_q[i] && (do_fill || (rank_q[i] < tgt_rank))) begin
          rank_d[i] = rank_q[i] + RankW'(1);
        end
      end
    end
    if (do_fill) begin
      valid_d = valid_q | tgt_oh;
    end
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= CfgFramesReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      frames_q <= cfg_i.frames_in_use;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_page_q <= req_page_w[PAGE_BITS-1:0];
      in_last_q <= req_i.last_request;
    end
  end

  // table control state, cleared after the last request of a sequence
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      faults_q <= '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (advance) begin
      if (in_last_q) begin
        valid_q  <= '0;
        faults_q <= '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
          rank_q[i] <= '0;
        end
      end else begin
        valid_q  <= valid_d;
        faults_q <= faults_d;
        for (int i = 0; i < MAX_FRAMES; i++) begin
          rank_q[i] <= rank_d[i];
        end
      end
    end
  end

  // page store, written on fill or replacement
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (advance && !hit && any_active && tgt_oh[i]) begin
        page_q[i] <= in_page_q;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_hit_q    <= hit;
      out_placed_q <= do_update;
      out_fidx_q   <= do_update ? tgt_idx_w[FrameIdxW-1:0] : '0;
      out_ev_q     <= !hit && any_active && !any_free;
      out_evpage_q <= (!hit && any_active && !any_free) ? evict_pg_w[PageW-1:0] : '0;
      out_fcnt_q   <= faults_d;
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.hit          = out_hit_q;
  assign res_o.placed       = out_placed_q;
  assign res_o.frame_index  = out_fidx_q;
  assign res_o.evicted      = out_ev_q;
  assign res_o.evicted_page = out_evpage_q;
  assign res_o.fault_count  = out_fcnt_q;

endmodule

`default_nettype wire
